[src/assert_macros.svh]
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_CLKD(lbl, clk, rstn, prop, msg) \
lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/plpl_pkg.sv]
package plpl_pkg;

	localparam int DEFAULT_MAX_POINTS = 16;
	localparam int QUEUE_DEPTH = 2;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_LOOKUP = 1'b1;

	localparam logic [2:0] REG_POINT_COUNT = 3'd0;
	localparam logic [2:0] REG_TRANSFORM_MODE = 3'd1;
	localparam logic [2:0] REG_SCORE_MODE = 3'd2;
	localparam logic [2:0] REG_MIN_LENGTH = 3'd3;
	localparam logic [2:0] REG_MAX_LENGTH = 3'd4;

	localparam logic signed [32:0] ADD_THREE = 33'sd196608;
	localparam logic signed [32:0] INT32_MAX = 33'sd2147483647;
	localparam logic [31:0] OOR_PENALTY = 32'h8000_0000;

	typedef struct packed {
		logic [4:0] point_count;
		logic transform_mode;
		logic score_mode;
		logic [15:0] min_length;
		logic [15:0] max_length;
	} cfg_t;

	// classified item handed from front to back
	typedef struct packed {
		logic is_load;
		logic oor;
		logic [3:0] slot;
		logic signed [31:0] limit;
		logic signed [31:0] pen;
		logic signed [31:0] v;
	} work_t;

	typedef struct packed {
		logic signed [31:0] penalty;
		logic out_of_range;
	} result_t;

endpackage

[src/piecewise_linear_penalty_lookup_core.sv]
// Piecewise linear penalty lookup. Breakpoints (limit, penalty, signed Q16.16) are loaded with
// action 0 into a slot and give no result; a lookup (action 1) gives one result, either the
// out-of-range flag with the most negative penalty or the clamped or interpolated penalty.
// Items enter a two-deep queue after the front classifies them; the back works on one item at
// a time. A load is written into the table as it leaves the queue. A lookup out of range goes
// straight to the output. An interpolating lookup is taken from the queue, scans the limits
// through the single table read port, does the neighbour reads and two multiplies, runs the
// one-bit-a-cycle divider, which sets most of the latency, and hands the result on. A lookup
// that clamps at an end or meets neighbours that do not bracket the value skips the arithmetic.
// Results wait in a two-deep output queue.
module piecewise_linear_penalty_lookup_core #(
	parameter int MAX_POINTS = plpl_pkg::DEFAULT_MAX_POINTS
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic action,
	input logic [3:0] point_index,
	input logic signed [31:0] limit_value,
	input logic signed [31:0] penalty_value,
	input logic signed [31:0] query_value,
	output logic empty,
	input logic pop,
	output logic signed [31:0] penalty,
	output logic out_of_range,
	input logic wr_en,
	input logic [2:0] wr_index,
	input logic [15:0] wr_data
);
	import plpl_pkg::*;

	cfg_t cfg_q;
	work_t work_in, work_out;
	result_t res_in, res_out;
	logic work_empty, work_pop, res_full, res_push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.point_count <= 5'd1;
			cfg_q.transform_mode <= 1'b0;
			cfg_q.score_mode <= 1'b0;
			cfg_q.min_length <= '0;
			cfg_q.max_length <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_POINT_COUNT: cfg_q.point_count <= wr_data[4:0];
				REG_TRANSFORM_MODE: cfg_q.transform_mode <= wr_data[0];
				REG_SCORE_MODE: cfg_q.score_mode <= wr_data[0];
				REG_MIN_LENGTH: cfg_q.min_length <= wr_data;
				REG_MAX_LENGTH: cfg_q.max_length <= wr_data;
				default: ;
			endcase
		end
	end

	plpl_front u_front (
		.cfg(cfg_q),
		.action(action),
		.point_index(point_index),
		.limit_value(limit_value),
		.penalty_value(penalty_value),
		.query_value(query_value),
		.work(work_in)
	);

	plpl_fifo #(.W($bits(work_t)), .D(QUEUE_DEPTH)) u_work_q (
		.clk(clk),
		.arst_n(arst_n),
		.wr(push),
		.wdata(work_in),
		.full(full),
		.rd(work_pop),
		.rdata(work_out),
		.empty(work_empty)
	);

	plpl_back #(.MAX_POINTS(MAX_POINTS)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.point_count(cfg_q.point_count),
		.work(work_out),
		.work_empty(work_empty),
		.work_pop(work_pop),
		.res(res_in),
		.res_full(res_full),
		.res_push(res_push)
	);

	plpl_fifo #(.W($bits(result_t)), .D(QUEUE_DEPTH)) u_res_q (
		.clk(clk),
		.arst_n(arst_n),
		.wr(res_push),
		.wdata(res_in),
		.full(res_full),
		.rd(pop),
		.rdata(res_out),
		.empty(empty)
	);

	assign penalty = res_out.penalty;
	assign out_of_range = res_out.out_of_range;
endmodule

[src/plpl_fifo.sv]
module plpl_fifo #(
	parameter int W = 8,
	parameter int D = plpl_pkg::QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic wr,
	input logic [W-1:0] wdata,
	output logic full,
	input logic rd,
	output logic [W-1:0] rdata,
	output logic empty
);
	localparam int AW = (D > 1) ? $clog2(D) : 1;
	localparam int CW = $clog2(D + 1);

	logic [W-1:0] mem_q [D];
	logic [AW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic do_wr, do_rd;

	assign full = (cnt_q == CW'(D));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == AW'(D - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= (rp_q == AW'(D - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wdata;
		end
	end
endmodule

[src/plpl_front.sv]
module plpl_front (
	input plpl_pkg::cfg_t cfg,
	input logic action,
	input logic [3:0] point_index,
	input logic signed [31:0] limit_value,
	input logic signed [31:0] penalty_value,
	input logic signed [31:0] query_value,
	output plpl_pkg::work_t work
);
	import plpl_pkg::*;

	logic signed [48:0] q_ext, min_ext, max_ext;
	logic signed [32:0] sum;

	always_comb begin
		q_ext = 49'(query_value);
		min_ext = $signed({1'b0, cfg.min_length, 16'b0});
		max_ext = $signed({1'b0, cfg.max_length, 16'b0});
		sum = 33'(query_value) + ADD_THREE;
		work.is_load = (action == ACT_LOAD);
		work.slot = point_index;
		work.limit = limit_value;
		work.pen = penalty_value;
		work.oor = !cfg.score_mode && (q_ext < min_ext || q_ext > max_ext);
		if (cfg.transform_mode) begin
			work.v = (sum > INT32_MAX) ? INT32_MAX[31:0] : sum[31:0];
		end else begin
			work.v = query_value;
		end
	end
endmodule

[src/plpl_back.sv]
module plpl_back #(
	parameter int MAX_POINTS = plpl_pkg::DEFAULT_MAX_POINTS
) (
	input logic clk,
	input logic arst_n,
	input logic [4:0] point_count,
	input plpl_pkg::work_t work,
	input logic work_empty,
	output logic work_pop,
	output plpl_pkg::result_t res,
	input logic res_full,
	output logic res_push
);
	import plpl_pkg::*;

	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SCAN = 4'd1;
	localparam logic [3:0] S_RDLO = 4'd2;
	localparam logic [3:0] S_RDHI = 4'd3;
	localparam logic [3:0] S_CHK = 4'd4;
	localparam logic [3:0] S_MUL = 4'd5;
	localparam logic [3:0] S_SUM = 4'd6;
	localparam logic [3:0] S_DIV = 4'd7;
	localparam logic [3:0] S_OUT = 4'd8;

	logic signed [31:0] limit_mem [MAX_POINTS];
	logic signed [31:0] pen_mem [MAX_POINTS];
	logic signed [31:0] rd_l_q, rd_p_q;
	logic [AW-1:0] rd_addr;

	logic [3:0] st_q;
	logic signed [31:0] v_q, l0_q, p0_q, l1_q;
	logic [CW-1:0] i_q, cnt_q, n, lo_addr, hi_addr;
	logic cmpv_q, is_end;
	logic signed [64:0] prod_a_q, prod_b_q;
	logic [31:0] den_q, rem_q;
	logic [63:0] dq_q;
	logic neg_q;
	logic [5:0] bit_q;
	logic [31:0] res_q;
	logic oor_q;

	logic [31:0] n32;
	logic wr_ok;
	logic signed [63:0] num;
	logic [32:0] trial;
	logic ge;

	always_comb begin
		if (point_count == 5'd0) begin
			n32 = 32'd1;
		end else if (32'(point_count) > 32'(MAX_POINTS)) begin
			n32 = 32'(MAX_POINTS);
		end else begin
			n32 = 32'(point_count);
		end
		n = n32[CW-1:0];
		is_end = (cnt_q == '0) || (cnt_q == n);
		lo_addr = (cnt_q == '0) ? '0 : cnt_q - 1'b1;
		hi_addr = is_end ? lo_addr : cnt_q;
		wr_ok = 32'(work.slot) < 32'(MAX_POINTS);
		num = 64'(prod_a_q + prod_b_q);
		trial = {rem_q, dq_q[63]};
		ge = trial >= {1'b0, den_q};
		case (st_q)
			S_SCAN: rd_addr = i_q[AW-1:0];
			S_RDLO: rd_addr = lo_addr[AW-1:0];
			default: rd_addr = hi_addr[AW-1:0];
		endcase
	end

	assign work_pop = (st_q == S_IDLE) && !work_empty;
	assign res_push = (st_q == S_OUT) && !res_full;
	assign res.penalty = res_q;
	assign res.out_of_range = oor_q;

	always_ff @(posedge clk) begin
		if (work_pop && work.is_load && wr_ok) begin
			limit_mem[AW'(work.slot)] <= work.limit;
			pen_mem[AW'(work.slot)] <= work.pen;
		end
		rd_l_q <= limit_mem[rd_addr];
		rd_p_q <= pen_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			cmpv_q <= 1'b0;
			i_q <= '0;
			cnt_q <= '0;
			bit_q <= '0;
		end else begin
			case (st_q)
				S_IDLE: begin
					if (work_pop && !work.is_load) begin
						v_q <= work.v;
						if (work.oor) begin
							res_q <= OOR_PENALTY;
							oor_q <= 1'b1;
							st_q <= S_OUT;
						end else begin
							oor_q <= 1'b0;
							i_q <= '0;
							cnt_q <= '0;
							cmpv_q <= 1'b0;
							st_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					// read port runs one entry ahead of the compare
					if (cmpv_q && rd_l_q <= v_q) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (i_q < n) begin
						i_q <= i_q + 1'b1;
						cmpv_q <= 1'b1;
					end else begin
						cmpv_q <= 1'b0;
						if (!cmpv_q) begin
							st_q <= S_RDLO;
						end
					end
				end
				S_RDLO: st_q <= S_RDHI;
				S_RDHI: begin
					l0_q <= rd_l_q;
					p0_q <= rd_p_q;
					st_q <= S_CHK;
				end
				S_CHK: begin
					if (is_end || !(l0_q <= v_q && v_q < rd_l_q)) begin
						res_q <= p0_q;
						st_q <= S_OUT;
					end else begin
						l1_q <= rd_l_q;
						den_q <= 32'(33'(rd_l_q) - 33'(l0_q));
						prod_a_q <= 65'(rd_p_q) * (33'(v_q) - 33'(l0_q));
						st_q <= S_MUL;
					end
				end
				S_MUL: begin
					prod_b_q <= 65'(p0_q) * (33'(l1_q) - 33'(v_q));
					st_q <= S_SUM;
				end
				S_SUM: begin
					neg_q <= num[63];
					dq_q <= num[63] ? 64'(-num) : 64'(num);
					rem_q <= '0;
					bit_q <= '0;
					st_q <= S_DIV;
				end
				S_DIV: begin
					// one quotient bit a cycle, restoring
					rem_q <= ge ? 32'(trial - {1'b0, den_q}) : trial[31:0];
					dq_q <= {dq_q[62:0], ge};
					bit_q <= bit_q + 1'b1;
					if (bit_q == 6'd63) begin
						st_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!res_full) begin
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
			if (st_q == S_DIV && bit_q == 6'd63) begin
				res_q <= neg_q ? 32'(-{dq_q[30:0], ge}) : {dq_q[30:0], ge};
			end
		end
	end
endmodule

[src/plpl_checker.sv]
`include "assert_macros.svh"

module plpl_checker (
	input logic clk,
	input logic arst_n,
	input logic empty,
	input logic pop,
	input logic [31:0] penalty,
	input logic out_of_range
);
	`ASSERT_CLKD(a_oor_penalty, clk, arst_n, !empty && out_of_range |-> penalty == 32'h8000_0000, "out of range item without most negative penalty")
	`ASSERT_CLKD(a_hold, clk, arst_n, !empty && !pop |=> !empty && $stable(penalty) && $stable(out_of_range), "waiting result changed")
	`ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |-> empty, "result queue not empty in reset")
endmodule

bind piecewise_linear_penalty_lookup_core plpl_checker u_plpl_checker (
	.clk(clk),
	.arst_n(arst_n),
	.empty(empty),
	.pop(pop),
	.penalty(penalty),
	.out_of_range(out_of_range)
);

[tb/piecewise_linear_penalty_lookup_core_tb.sv]
`timescale 1ns / 100ps

import plpl_pkg::*;

class penalty_scoreboard;
	logic [4:0] used_points;
	logic add_three;
	logic score_only;
	logic [15:0] min_len;
	logic [15:0] max_len;
	int limit_tab[16];
	int penalty_tab[16];
	result_t pending_q[$];
	int errors;

	function void reset_regs();
		used_points = 5'd1;
		add_three = 1'b0;
		score_only = 1'b0;
		min_len = '0;
		max_len = '0;
		errors = 0;
	endfunction

	function void write_reg(logic [2:0] idx, logic [15:0] data);
		case (idx)
			REG_POINT_COUNT: used_points = data[4:0];
			REG_TRANSFORM_MODE: add_three = data[0];
			REG_SCORE_MODE: score_only = data[0];
			REG_MIN_LENGTH: min_len = data;
			REG_MAX_LENGTH: max_len = data;
			default: ;
		endcase
	endfunction

	function result_t predict_result(int query);
		result_t res;
		longint v, l0, l1, p0, p1, num;
		int n, below;
		v = query;
		res.out_of_range = 1'b0;
		if (!score_only && (v < longint'(min_len) * 65536 || v > longint'(max_len) * 65536)) begin
			res.penalty = OOR_PENALTY;
			res.out_of_range = 1'b1;
			return res;
		end
		if (add_three) begin
			v = v + 196608;
			if (v > 64'sd2147483647)
				v = 64'sd2147483647;
		end
		n = (used_points == 0) ? 1 : (used_points > 16) ? 16 : used_points;
		below = 0;
		for (int i = 0; i < n; i++)
			if (longint'(limit_tab[i]) <= v)
				below++;
		if (below == 0) begin
			res.penalty = penalty_tab[0];
		end else if (below == n) begin
			res.penalty = penalty_tab[n - 1];
		end else begin
			l0 = limit_tab[below - 1];
			l1 = limit_tab[below];
			p0 = penalty_tab[below - 1];
			p1 = penalty_tab[below];
			// neighbours that do not bracket the value give the lower neighbour's penalty
			if (!(l0 <= v && v < l1)) begin
				res.penalty = p0[31:0];
			end else begin
				num = p1 * (v - l0) + p0 * (l1 - v);
				num = num / (l1 - l0);
				res.penalty = num[31:0];
			end
		end
		return res;
	endfunction

	function void note_item(logic act, logic [3:0] slot, int lim, int pen, int query);
		if (act == ACT_LOAD) begin
			limit_tab[slot] = lim;
			penalty_tab[slot] = pen;
		end else begin
			pending_q.push_back(predict_result(query));
		end
	endfunction

	task report(string what);
		errors++;
		$display("mismatch: %s", what);
	endtask

	task check_result(logic signed [31:0] pen, logic oor);
		result_t want;
		if (pending_q.size() == 0) begin
			report($sformatf("unexpected result penalty %h oor %b", pen, oor));
		end else begin
			want = pending_q.pop_front();
			if (pen !== want.penalty)
				report($sformatf("penalty %h, expected %h", pen, want.penalty));
			if (oor !== want.out_of_range)
				report($sformatf("out_of_range %b, expected %b", oor, want.out_of_range));
		end
	endtask
endclass

module piecewise_linear_penalty_lookup_core_tb;
	localparam int CYCLE_LIMIT = 1500000;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	logic action;
	logic [3:0] point_index;
	logic signed [31:0] limit_value;
	logic signed [31:0] penalty_value;
	logic signed [31:0] query_value;
	logic empty;
	logic pop;
	logic signed [31:0] penalty;
	logic out_of_range;
	logic wr_en;
	logic [2:0] wr_index;
	logic [15:0] wr_data;

	penalty_scoreboard sb;
	int cycles;
	int sent;
	bit calm;
	int pop_hold;
	int table_q[$];

	piecewise_linear_penalty_lookup_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.action(action),
		.point_index(point_index),
		.limit_value(limit_value),
		.penalty_value(penalty_value),
		.query_value(query_value),
		.empty(empty),
		.pop(pop),
		.penalty(penalty),
		.out_of_range(out_of_range),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("piecewise_linear_penalty_lookup_core_tb: done, errors");
			$finish;
		end
	end

	// values seen here are the ones from before the edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full)
				sb.note_item(action, point_index, limit_value, penalty_value, query_value);
			if (pop && !empty)
				sb.check_result(penalty, out_of_range);
		end
	end

	always @(posedge clk) begin
		if (pop_hold > 0) begin
			pop_hold--;
			pop <= 1'b0;
		end else if (!calm && $urandom_range(0, 11) == 0) begin
			pop_hold = $urandom_range(0, 14);
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	task send_item(logic act, logic [3:0] slot, int lim, int pen, int query);
		if (!calm && $urandom_range(0, 9) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		push <= 1'b1;
		action <= act;
		point_index <= slot;
		limit_value <= lim;
		penalty_value <= pen;
		query_value <= query;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sent++;
		if (sent >= 700)
			calm = 1'b1;
	endtask

	task load(logic [3:0] slot, int lim, int pen);
		send_item(ACT_LOAD, slot, lim, pen, $urandom);
	endtask

	task lookup(int query);
		send_item(ACT_LOOKUP, 4'($urandom), $urandom, $urandom, query);
	endtask

	// wait for every result, then for loads still inside the block
	task drain();
		push <= 1'b0;
		@(posedge clk);
		while (sb.pending_q.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	// dropping wr_en after each write keeps back-to-back writes apart
	task write_reg(logic [2:0] idx, logic [15:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		sb.write_reg(idx, data);
		@(posedge clk);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task load_table(bit ordered);
		table_q.delete();
		for (int i = 0; i < 16; i++)
			table_q.push_back($urandom);
		if (ordered)
			table_q.sort();
		for (int i = 0; i < 16; i++)
			load(4'(i), table_q[i], $urandom);
	endtask

	function int pick_query();
		int j;
		longint lo, hi;
		j = $urandom_range(0, 14);
		case ($urandom_range(0, 9))
			0, 1: return $urandom;
			2: return table_q[j];
			3: return table_q[j] - 196608;
			default: begin
				lo = table_q[j];
				hi = table_q[j + 1];
				if (hi <= lo)
					return table_q[j];
				return int'(lo + ({$urandom, $urandom} % (hi - lo)));
			end
		endcase
	endfunction

	initial begin
		int n;
		sb = new();
		sb.reset_regs();
		cycles = 0;
		sent = 0;
		calm = 1'b0;
		pop_hold = 0;
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		action = ACT_LOAD;
		point_index = '0;
		limit_value = '0;
		penalty_value = '0;
		query_value = '0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// small ordered table, every slot written before any lookup
		for (int i = 0; i < 16; i++)
			load(4'(i), (i * 10 - 5) * 65536, i * 1000 * 65536 + 12345);
		load(0, 32'sh8000_0000, 32'sh7fff_ffff);
		load(15, 32'sh7fff_ffff, 32'sh8000_0000);
		drain();
		write_reg(REG_POINT_COUNT, 16'd4);
		write_reg(REG_MIN_LENGTH, 16'd2);
		write_reg(REG_MAX_LENGTH, 16'd25);
		write_reg(3'd5, 16'hffff);
		write_reg(3'd7, 16'h0000);
		lookup(2 * 65536 - 1);
		lookup(2 * 65536);
		lookup(25 * 65536);
		lookup(25 * 65536 + 1);
		lookup(7 * 65536 + 3);
		lookup(32'sh8000_0000);
		lookup(32'sh7fff_ffff);
		drain();
		write_reg(REG_SCORE_MODE, 16'd1);
		write_reg(REG_TRANSFORM_MODE, 16'd1);
		lookup(32'sh7fff_ffff);
		lookup(32'sh7ffd_0001);
		lookup(32'sh8000_0000);
		lookup(-65536);
		lookup(12 * 65536);
		drain();
		write_reg(REG_TRANSFORM_MODE, 16'd0);
		write_reg(REG_POINT_COUNT, 16'd0);
		lookup(32'sh7fff_ffff);
		drain();
		write_reg(REG_POINT_COUNT, 16'd31);
		lookup(32'sh7fff_ffff);
		lookup(100 * 65536);
		// limits out of order: for the first lookup the neighbours fail to bracket the value
		load(0, 100, 77);
		load(1, 0, 88);
		load(2, 200, 99);
		drain();
		write_reg(REG_POINT_COUNT, 16'd3);
		lookup(50);
		lookup(150);
		drain();

		while (sent < 850) begin
			n = $urandom_range(0, 5);
			write_reg(REG_POINT_COUNT, (n == 0) ? 16'(($urandom_range(0, 4) == 0) ? 0 :
				$urandom_range(17, 31)) : 16'($urandom_range(1, 16)));
			write_reg(REG_TRANSFORM_MODE, 16'($urandom_range(0, 1)));
			write_reg(REG_SCORE_MODE, 16'($urandom_range(0, 2) != 0));
			n = $urandom_range(0, 3);
			write_reg(REG_MIN_LENGTH, (n == 0) ? 16'd0 : 16'($urandom_range(0, 200)));
			write_reg(REG_MAX_LENGTH, (n == 1) ? 16'hffff : 16'($urandom));
			load_table($urandom_range(0, 7) != 0);
			repeat (80) begin
				if ($urandom_range(0, 9) == 0)
					load(4'($urandom), $urandom, $urandom);
				else
					lookup(pick_query());
			end
			drain();
		end

		if (sb.pending_q.size() != 0)
			sb.report($sformatf("%0d results never came", sb.pending_q.size()));
		if (sb.errors == 0)
			$display("piecewise_linear_penalty_lookup_core_tb: done, clean");
		else
			$display("piecewise_linear_penalty_lookup_core_tb: done, errors");
		$finish;
	end
endmodule
